// ===== design/sts_pkg.sv =====
// ----------------------------------------------------------------------------
// sts_pkg
// Shared types and constants of the sorted table binary search block.
// ----------------------------------------------------------------------------
package sts_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int SLOT_W          = 10;
    localparam int DATA_W          = 32;
    localparam int SIZE_W          = 11;
    localparam int POS_W           = 10;

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    typedef struct packed {
        logic                     req_type;
        logic [SLOT_W-1:0]        slot;
        logic signed [DATA_W-1:0] data_value;
    } t_req;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } t_rsp;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_COMPARE
    } t_state;

endpackage

// ===== design/sts_ram.sv =====
// ----------------------------------------------------------------------------
// sts_ram
// Entry table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sts_ram #(
    parameter int DEPTH = sts_pkg::TABLE_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [AW-1:0]                    i_waddr,
    input  logic signed [sts_pkg::DATA_W-1:0] i_wdata,
    input  logic                             i_re,
    input  logic [AW-1:0]                    i_raddr,
    output logic signed [sts_pkg::DATA_W-1:0] o_rdata
);

    logic signed [sts_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic signed [sts_pkg::DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/sts_ctrl.sv =====
// ----------------------------------------------------------------------------
// sts_ctrl
// Search sequencer: holds the size register, steers loads into the table and
// walks the probe sequence, one table read and one compare per probe.
// ----------------------------------------------------------------------------
module sts_ctrl #(
    parameter int TABLE_DEPTH = sts_pkg::TABLE_DEPTH_DEF,
    parameter int AW          = $clog2(TABLE_DEPTH),
    parameter int CW          = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  sts_pkg::t_req                     i_req,
    input  logic                              i_cfg_we,
    input  logic [sts_pkg::SIZE_W-1:0]        i_cfg_wdata,
    output logic                              o_valid,
    output sts_pkg::t_rsp                     o_rsp,
    output logic                              o_we,
    output logic [AW-1:0]                     o_waddr,
    output logic signed [sts_pkg::DATA_W-1:0] o_wdata,
    output logic                              o_re,
    output logic [AW-1:0]                     o_raddr,
    input  logic signed [sts_pkg::DATA_W-1:0] i_rdata
);

    sts_pkg::t_state r_state, n_state;

    logic [sts_pkg::SIZE_W-1:0]        r_size;
    logic [CW-1:0]                     r_lo, n_lo;
    logic [CW-1:0]                     r_hi, n_hi;
    logic [CW-1:0]                     r_mid, n_mid;
    logic signed [sts_pkg::DATA_W-1:0] r_key, n_key;
    logic                              r_valid, n_valid;
    sts_pkg::t_rsp                     r_rsp, n_rsp;

    logic          w_accept;
    logic [CW:0]   w_sum;
    logic [CW-1:0] w_mid;
    logic [CW-1:0] w_count;

    assign w_accept = start && (r_state == sts_pkg::ST_IDLE);

    // A configured size above the table depth is treated as the full depth.
    assign w_count = (32'(r_size) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(r_size);

    // The range is held half open as [lo, hi); the midpoint is floor((lo+hi-1)/2).
    assign w_sum = (CW+1)'(r_lo) + (CW+1)'(r_hi) - (CW+1)'(1);
    assign w_mid = w_sum[CW:1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= '0;
        end else if (i_cfg_we) begin
            r_size <= i_cfg_wdata;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            sts_pkg::ST_IDLE: begin
                if (w_accept && i_req.req_type == sts_pkg::REQ_SEARCH) begin
                    n_state = sts_pkg::ST_ISSUE;
                end
            end
            sts_pkg::ST_ISSUE: begin
                n_state = (r_lo < r_hi) ? sts_pkg::ST_COMPARE : sts_pkg::ST_IDLE;
            end
            sts_pkg::ST_COMPARE: begin
                n_state = (r_key == i_rdata) ? sts_pkg::ST_IDLE : sts_pkg::ST_ISSUE;
            end
            default: n_state = sts_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_mid   = r_mid;
        n_key   = r_key;
        n_valid = 1'b0;
        n_rsp   = r_rsp;
        o_re    = 1'b0;
        case (r_state)
            sts_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_lo  = '0;
                    n_hi  = w_count;
                    n_key = i_req.data_value;
                end
            end
            sts_pkg::ST_ISSUE: begin
                if (r_lo < r_hi) begin
                    o_re  = 1'b1;
                    n_mid = w_mid;
                end else begin
                    n_valid        = 1'b1;
                    n_rsp.found    = 1'b0;
                    n_rsp.position = '0;
                end
            end
            sts_pkg::ST_COMPARE: begin
                if (r_key < i_rdata) begin
                    n_hi = r_mid;
                end else if (r_key > i_rdata) begin
                    n_lo = r_mid + CW'(1);
                end else begin
                    n_valid        = 1'b1;
                    n_rsp.found    = 1'b1;
                    n_rsp.position = sts_pkg::POS_W'(r_mid);
                end
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sts_pkg::ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_mid <= n_mid;
        r_key <= n_key;
        r_rsp <= n_rsp;
    end

    // A load is written straight into the table at the edge that accepts it.
    assign o_we    = w_accept && (i_req.req_type == sts_pkg::REQ_LOAD)
                     && (32'(i_req.slot) < 32'(TABLE_DEPTH));
    assign o_waddr = AW'(i_req.slot);
    assign o_wdata = i_req.data_value;
    assign o_raddr = AW'(w_mid);

    assign busy    = (r_state != sts_pkg::ST_IDLE);
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule

// ===== design/sorted_table_binary_search.sv =====
// ----------------------------------------------------------------------------
// sorted_table_binary_search
// Sorted table of signed entries with load and binary search commands.
//
//   Channel   Ports                     Handshake
//   request   start, busy, i_req        taken when start high and busy low
//   result    o_valid, o_rsp            one-cycle strobe, cannot be held off
//   config    i_cfg_we, i_cfg_wdata     written when i_cfg_we high
//
// A load writes the table at the accepting edge.
// A search keeps busy high through its probes and, after a miss, through a
// final issue state that finds the range empty; the result strobe follows in
// the next cycle, when the next item may already be taken. A search makes at
// most ceil(log2(n+1)) probes for an n-entry table. Each probe is one table
// read and one compare, held in an issue state and a compare state, since
// the table memory gives registered read data.
// Reset is synchronous and clears the size register and the sequencer; the
// table contents are not cleared. The result strobe is never stalled.
// ----------------------------------------------------------------------------
module sorted_table_binary_search #(
    parameter int TABLE_DEPTH = sts_pkg::TABLE_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  sts_pkg::t_req              i_req,
    input  logic                       i_cfg_we,
    input  logic [sts_pkg::SIZE_W-1:0] i_cfg_wdata,
    output logic                       o_valid,
    output sts_pkg::t_rsp              o_rsp
);

    localparam int AW = $clog2(TABLE_DEPTH);

    logic                              w_we;
    logic [AW-1:0]                     w_waddr;
    logic signed [sts_pkg::DATA_W-1:0] w_wdata;
    logic                              w_re;
    logic [AW-1:0]                     w_raddr;
    logic signed [sts_pkg::DATA_W-1:0] w_rdata;

    sts_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_valid     (o_valid),
        .o_rsp       (o_rsp),
        .o_we        (w_we),
        .o_waddr     (w_waddr),
        .o_wdata     (w_wdata),
        .o_re        (w_re),
        .o_raddr     (w_raddr),
        .i_rdata     (w_rdata)
    );

    sts_ram #(
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // A result is only given as the sequencer returns to idle.
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while a search is still running");

    // A miss always reports slot zero.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_rsp.found) |-> (o_rsp.position == '0))
        else $error("miss reported with a non-zero position");

    // A search item always occupies the sequencer in the following cycle.
    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req.req_type == sts_pkg::REQ_SEARCH) |=> busy)
        else $error("search item accepted but sequencer not busy");

    // A load item produces no result.
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req.req_type == sts_pkg::REQ_LOAD) |=> !o_valid)
        else $error("load item followed by a result strobe");

endmodule
